// ===== src/jacobi_heat_plate_relaxation_unit_assert.svh =====
// Assertion macros shared by the checker files of the relaxation unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef JACOBI_HEAT_PLATE_RELAXATION_UNIT_ASSERT_SVH
`define JACOBI_HEAT_PLATE_RELAXATION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JHP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jhp_pkg.sv =====
`timescale 1ns / 1ps

package jhp_pkg;

    localparam int CELL_W       = 24;
    localparam int ACC_W        = 26;
    localparam int CMD_W        = 2;
    localparam int COORD_W      = 7;
    localparam int SWEEP_W      = 16;
    localparam int SIZE_W       = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 72;

    localparam int DEFAULT_GRID_SIZE = 128;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SIZE = 1'b1;

    localparam logic [SWEEP_W-1:0] RESET_SWEEP_COUNT = 16'd1000;
    localparam logic [SIZE_W-1:0]  RESET_ACTIVE_SIZE = 8'd128;

    localparam logic [CELL_W-1:0] CELL_ONES = {CELL_W{1'b1}};

    // Sideband that travels with each sweep read to the accumulator.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic interior;
    } tag_t;

    typedef struct packed {
        logic              kind;
        logic [CELL_W-1:0] max_value;
        logic [CELL_W-1:0] min_value;
        logic [CELL_W-1:0] cell_value;
    } result_t;

    typedef enum logic [3:0] {
        SEQ_IDLE  = 4'b0001,
        SEQ_SWEEP = 4'b0010,
        SEQ_DRAIN = 4'b0100,
        SEQ_DONE  = 4'b1000
    } seq_state_t;

endpackage

// ===== src/jacobi_heat_plate_relaxation_unit.sv =====
`timescale 1ns / 1ps
// Jacobi heat-plate relaxation unit.
// Commands arrive on the slave stream (s_*): tuser carries the command, tdata carries
// row, column and temperature. A write stores one cell, a read returns one cell, and a
// run performs the configured number of five-point Jacobi sweeps over the active square.
// Results leave on the master stream (m_*): tuser says read data or run finished.
// Writes and reads are taken one per cycle while s_tready is high; a read result passes
// through the registered memory read and the result queue register before it appears.
// A run holds s_tready low until it reports. A sweep visits each cell of the m-by-m square,
// with n the active size and m the larger of n and the last swept run's size. Interior cells
// take four reads: the plate memory's single read port fetches one neighbor per cycle.
// Two plate banks alternate each sweep; writes go to both so border cells agree.
// Reset clears the control state and the configuration (1000 sweeps, size 128); plate
// contents are undefined until written. A stalled receiver fills the two-entry result
// queue, after which s_tready drops until a result transaction drains it.
// The user must write the configuration port only while no command is in flight; the block does not enforce it.

module jacobi_heat_plate_relaxation_unit #(
    parameter int GRID_SIZE = jhp_pkg::DEFAULT_GRID_SIZE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jhp_pkg::IN_TDATA_W-1:0]    s_tdata,   // row[6:0], col[13:7], value[37:14]
    input  logic [jhp_pkg::CMD_W-1:0]         s_tuser,   // cmd[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jhp_pkg::OUT_TDATA_W-1:0]   m_tdata,   // cell_value, min_value, max_value
    output logic                              m_tuser,   // result_kind[0]
    input  logic                              cfg_we,
    input  logic [jhp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jhp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import jhp_pkg::*;

    localparam int NW    = $clog2(GRID_SIZE + 1);
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers.
    logic [SWEEP_W-1:0] sweep_count_reg;
    logic [SIZE_W-1:0]  active_size_reg;
    logic [NW-1:0]      n_eff;

    // Command decode.
    logic [CMD_W-1:0]   in_cmd;
    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;
    logic [CELL_W-1:0]  in_value;
    logic               in_grid;
    logic [AW-1:0]      cmd_addr;
    logic               accept;
    logic               wr_cmd;
    logic               rd_cmd;
    logic               run_cmd;

    // Sweep engine.
    logic               seq_busy;
    logic               seq_done;
    logic               cur_bank;
    logic [AW-1:0]      seq_rd_addr;
    logic [AW-1:0]      seq_cell_addr;
    tag_t               seq_tag;
    logic               acc_we;
    logic [AW-1:0]      acc_waddr;
    logic [CELL_W-1:0]  acc_wdata;
    logic [CELL_W-1:0]  run_min;
    logic [CELL_W-1:0]  run_max;

    // Plate banks.
    logic               we_a, we_b;
    logic [AW-1:0]      waddr;
    logic [CELL_W-1:0]  wdata;
    logic [AW-1:0]      raddr;
    logic [CELL_W-1:0]  rdata_a, rdata_b, rdata_cur;

    // Result queue.
    logic               rd_pend_reg;
    logic               rd_inside_reg;
    result_t            fifo_reg [2];
    logic               wptr_reg, rptr_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push, pop;
    result_t            push_data;
    result_t            head;
    logic               room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_count_reg <= RESET_SWEEP_COUNT;
            active_size_reg <= RESET_ACTIVE_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SWEEP_COUNT: sweep_count_reg <= cfg_data;
                CFG_ACTIVE_SIZE: active_size_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes above the grid are clamped to it.
    assign n_eff = (int'(active_size_reg) > GRID_SIZE) ? NW'(GRID_SIZE) : NW'(active_size_reg);

    assign in_cmd   = s_tuser;
    assign in_row   = s_tdata[6:0];
    assign in_col   = s_tdata[13:7];
    assign in_value = s_tdata[37:14];
    assign in_grid  = (int'(in_row) < GRID_SIZE) && (int'(in_col) < GRID_SIZE);
    assign cmd_addr = AW'(in_row) * AW'(GRID_SIZE) + AW'(in_col);

    // Accept only when the queue can hold every result already on its way.
    assign room     = ({1'b0, cnt_reg} + {2'b00, rd_pend_reg}) <= (3'd1 + {2'b00, pop});
    assign s_tready = !seq_busy && room;
    assign accept   = s_tvalid && s_tready;
    assign wr_cmd   = accept && (in_cmd == CMD_WRITE) && in_grid;
    assign rd_cmd   = accept && (in_cmd == CMD_READ);
    assign run_cmd  = accept && (in_cmd == CMD_RUN);

    jhp_seq #(
        .GRID_SIZE (GRID_SIZE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (run_cmd),
        .sweep_count (sweep_count_reg),
        .n_size      (n_eff),
        .busy        (seq_busy),
        .done        (seq_done),
        .cur_bank    (cur_bank),
        .rd_addr     (seq_rd_addr),
        .cell_addr   (seq_cell_addr),
        .tag         (seq_tag)
    );

    jhp_accum #(
        .GRID_SIZE (GRID_SIZE)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (run_cmd),
        .tag       (seq_tag),
        .cell_addr (seq_cell_addr),
        .rdata     (rdata_cur),
        .we        (acc_we),
        .waddr     (acc_waddr),
        .wdata     (acc_wdata),
        .min_value (run_min),
        .max_value (run_max)
    );

    // A sweep reads the current bank and writes the other; host writes hit both banks.
    assign raddr = seq_busy ? seq_rd_addr : cmd_addr;
    assign waddr = seq_busy ? acc_waddr : cmd_addr;
    assign wdata = seq_busy ? acc_wdata : in_value;
    assign we_a  = wr_cmd || (acc_we && cur_bank);
    assign we_b  = wr_cmd || (acc_we && !cur_bank);
    assign rdata_cur = cur_bank ? rdata_b : rdata_a;

    jhp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    jhp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    always_comb
    begin
        push_data = '0;
        if (rd_pend_reg)
        begin
            push_data.kind       = KIND_READ;
            push_data.cell_value = rd_inside_reg ? rdata_cur : '0;
        end
        else
        begin
            push_data.kind      = KIND_RUN;
            push_data.min_value = run_min;
            push_data.max_value = run_max;
        end
    end

    assign push     = rd_pend_reg || seq_done;
    assign pop      = m_tvalid && m_tready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    assign head     = fifo_reg[rptr_reg];

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = head.kind;
    assign m_tdata  = {head.max_value, head.min_value, head.cell_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            wptr_reg    <= 1'b0;
            rptr_reg    <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            rd_pend_reg <= rd_cmd;
            cnt_reg     <= cnt_next;
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_inside_reg <= in_grid;
        if (push)
        begin
            fifo_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/jhp_ram.sv =====
`timescale 1ns / 1ps

module jhp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/jhp_seq.sv =====
`timescale 1ns / 1ps

module jhp_seq #(
    parameter int GRID_SIZE = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [jhp_pkg::SWEEP_W-1:0]           sweep_count,
    input  logic [$clog2(GRID_SIZE+1)-1:0]        n_size,
    output logic                                  busy,
    output logic                                  done,
    output logic                                  cur_bank,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] cell_addr,
    output jhp_pkg::tag_t                         tag
);
    import jhp_pkg::*;

    localparam int CW = $clog2(GRID_SIZE);
    localparam int NW = $clog2(GRID_SIZE + 1);
    localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      r_reg, r_next;
    logic [CW-1:0]      c_reg, c_next;
    logic [1:0]         phase_reg, phase_next;
    logic [SWEEP_W-1:0] left_reg, left_next;
    logic [NW-1:0]      m_reg, m_next;
    logic [NW-1:0]      dirty_reg, dirty_next;
    logic               bank_reg, bank_next;

    logic          interior;
    logic          last_phase;
    logic          c_end;
    logic          r_end;
    logic [NW:0]   r_ext;
    logic [NW:0]   c_ext;
    logic [NW:0]   n_ext;

    assign r_ext = (NW+1)'(r_reg);
    assign c_ext = (NW+1)'(c_reg);
    assign n_ext = (NW+1)'(n_size);

    // Interior of the active square: rows and columns 1 .. n-2.
    assign interior = (r_reg != '0) && (c_reg != '0)
                   && (r_ext + (NW+1)'(2) <= n_ext) && (c_ext + (NW+1)'(2) <= n_ext);
    assign last_phase = interior ? (phase_reg == 2'd3) : 1'b1;
    assign c_end = (NW'(c_reg) + NW'(1)) == m_reg;
    assign r_end = (NW'(r_reg) + NW'(1)) == m_reg;

    assign cell_addr = AW'(r_reg) * AW'(GRID_SIZE) + AW'(c_reg);

    always_comb
    begin
        rd_addr = cell_addr;
        case (phase_reg)
            2'd0: rd_addr = interior ? cell_addr - AW'(GRID_SIZE) : cell_addr;
            2'd1: rd_addr = cell_addr + AW'(GRID_SIZE);
            2'd2: rd_addr = cell_addr - AW'(1);
            default: rd_addr = cell_addr + AW'(1);
        endcase
    end

    assign tag.valid    = (state_reg == SEQ_SWEEP);
    assign tag.first    = (phase_reg == 2'd0);
    assign tag.last     = last_phase;
    assign tag.interior = interior;

    assign busy     = (state_reg != SEQ_IDLE);
    assign done     = (state_reg == SEQ_DONE);
    assign cur_bank = bank_reg;

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        phase_next = phase_reg;
        left_next  = left_reg;
        m_next     = m_reg;
        dirty_next = dirty_reg;
        bank_next  = bank_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    // Banks may differ inside the last run's square; sweep over it too.
                    m_next     = (n_size > dirty_reg) ? n_size : dirty_reg;
                    r_next     = '0;
                    c_next     = '0;
                    phase_next = 2'd0;
                    left_next  = sweep_count;
                    if ((sweep_count == '0) || (n_size < NW'(3)))
                    begin
                        state_next = SEQ_DONE;
                    end
                    else
                    begin
                        state_next = SEQ_SWEEP;
                    end
                end
            end
            SEQ_SWEEP:
            begin
                if (last_phase)
                begin
                    phase_next = 2'd0;
                    if (c_end)
                    begin
                        c_next = '0;
                        if (r_end)
                        begin
                            r_next     = '0;
                            state_next = SEQ_DRAIN;
                        end
                        else
                        begin
                            r_next = r_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + CW'(1);
                    end
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            SEQ_DRAIN:
            begin
                bank_next = ~bank_reg;
                if (left_reg == SWEEP_W'(1))
                begin
                    dirty_next = n_size;
                    state_next = SEQ_DONE;
                end
                else
                begin
                    left_next  = left_reg - SWEEP_W'(1);
                    state_next = SEQ_SWEEP;
                end
            end
            SEQ_DONE:
            begin
                state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            phase_reg <= 2'd0;
            left_reg  <= '0;
            m_reg     <= '0;
            dirty_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
            m_reg     <= m_next;
            dirty_reg <= dirty_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== src/jhp_accum.sv =====
`timescale 1ns / 1ps

module jhp_accum #(
    parameter int GRID_SIZE = 128
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   clear,
    input  jhp_pkg::tag_t                          tag,
    input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] cell_addr,
    input  logic [jhp_pkg::CELL_W-1:0]             rdata,
    output logic                                   we,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] waddr,
    output logic [jhp_pkg::CELL_W-1:0]             wdata,
    output logic [jhp_pkg::CELL_W-1:0]             min_value,
    output logic [jhp_pkg::CELL_W-1:0]             max_value
);
    import jhp_pkg::*;

    localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

    tag_t              tag_reg;
    logic [AW-1:0]     dest_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CELL_W-1:0] min_reg, min_next;
    logic [CELL_W-1:0] max_reg, max_next;
    logic [ACC_W-1:0]  sum;

    // Read data lines up with the tag captured in the issue cycle.
    assign sum   = tag_reg.first ? ACC_W'(rdata) : acc_reg + ACC_W'(rdata);
    assign we    = tag_reg.valid && tag_reg.last;
    assign waddr = dest_reg;
    assign wdata = tag_reg.interior ? sum[ACC_W-1:2] : rdata;

    assign min_value = min_reg;
    assign max_value = max_reg;

    always_comb
    begin
        acc_next = tag_reg.valid ? sum : acc_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (clear)
        begin
            min_next = CELL_ONES;
            max_next = '0;
        end
        else if (we && tag_reg.interior)
        begin
            if (wdata < min_reg)
            begin
                min_next = wdata;
            end
            if (wdata > max_reg)
            begin
                max_next = wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
            min_reg <= CELL_ONES;
            max_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= cell_addr;
        acc_reg  <= acc_next;
    end

endmodule

// ===== src/jhp_checker.sv =====
`timescale 1ns / 1ps
`include "jacobi_heat_plate_relaxation_unit_assert.svh"

module jhp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [jhp_pkg::CMD_W-1:0]       s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [jhp_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import jhp_pkg::*;

    `JHP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `JHP_ASSERT_SAME(a_read_no_stats, m_tvalid && (m_tuser == KIND_READ), m_tdata[71:24] == '0, "read result carries run statistics")
    `JHP_ASSERT_SAME(a_run_no_cell, m_tvalid && (m_tuser == KIND_RUN), m_tdata[23:0] == '0, "run result carries cell data")
    `JHP_ASSERT_NEXT(a_run_busy, s_tvalid && s_tready && (s_tuser == CMD_RUN), !s_tready, "command taken during a run")

endmodule

bind jacobi_heat_plate_relaxation_unit jhp_checker u_jhp_checker (.*);

// ===== test/jacobi_heat_plate_relaxation_unit_test.sv =====
`timescale 1ns / 1ps

// Testbench for the relaxation unit. A mirror of the plate, written in plain
// SystemVerilog, follows every command as it is accepted and queues the report
// that the unit owes for it. A single checking process takes each report
// transaction off the master stream and compares it field by field with the
// oldest queued report.
//
// The first test loads a square in the top-left corner of the plate, and every
// later read or run stays inside it, so only cells that hold a written value are
// ever read or swept.
module jacobi_heat_plate_relaxation_unit_test;
    import jhp_pkg::*;

    localparam int GRID          = DEFAULT_GRID_SIZE;
    localparam int CELLS         = GRID * GRID;
    localparam int LOAD_SIZE     = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTED  = 10;
    localparam int RANDOM_ITEMS  = 250;

    // The slowest run issued here is 65535 sweeps over a 3x3 square; the limit allows for it
    // in case the unit does not stop once the plate has settled.
    localparam int STALL_LIMIT = 4_000_000;

    // Command code 3 has no meaning and must be dropped silently.
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // row[6:0], col[13:7], value[37:14], zero pad
    logic [CMD_W-1:0]       s_tuser;   // cmd[1:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // cell_value[23:0], min_value[47:24], max_value[71:48]
    logic                   m_tuser;   // result_kind[0]
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    jacobi_heat_plate_relaxation_unit #(
        .GRID_SIZE(GRID)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the unit: plate contents, sweep scratch and both registers.
    logic [CELL_W-1:0]  plate_mirror [CELLS];
    logic [CELL_W-1:0]  sweep_scratch [CELLS];
    logic [SWEEP_W-1:0] mirror_sweeps;
    logic [SIZE_W-1:0]  mirror_size;

    // Reports the unit still owes, oldest first.
    result_t pending_reports [$];

    int mismatches;
    int commands_sent;
    int send_gap_max;
    int take_gap_max;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One full run of Jacobi sweeps over the mirror. Every interior cell of the
    // active square takes the truncated quarter of its four neighbors from the
    // previous sweep. The run stops early once a sweep leaves the plate unchanged,
    // since every later sweep would repeat it exactly.
    task automatic relax_mirror(output logic [CELL_W-1:0] lo, output logic [CELL_W-1:0] hi);
        int n;
        int c;
        logic moved;
        logic [ACC_W-1:0] acc;
        n = (mirror_size > GRID) ? GRID : int'(mirror_size);
        lo = CELL_ONES;
        hi = '0;
        if (n < 3)
        begin
            return;
        end
        for (int t = 0; t < int'(mirror_sweeps); t++)
        begin
            moved = 1'b0;
            for (int i = 1; i < n - 1; i++)
            begin
                for (int j = 1; j < n - 1; j++)
                begin
                    c = i * GRID + j;
                    acc = ACC_W'(plate_mirror[c - GRID]) + ACC_W'(plate_mirror[c + GRID])
                        + ACC_W'(plate_mirror[c - 1]) + ACC_W'(plate_mirror[c + 1]);
                    sweep_scratch[c] = acc[ACC_W-1:2];
                    if (sweep_scratch[c] < lo)
                    begin
                        lo = sweep_scratch[c];
                    end
                    if (sweep_scratch[c] > hi)
                    begin
                        hi = sweep_scratch[c];
                    end
                end
            end
            for (int i = 1; i < n - 1; i++)
            begin
                for (int j = 1; j < n - 1; j++)
                begin
                    c = i * GRID + j;
                    if (plate_mirror[c] != sweep_scratch[c])
                    begin
                        moved = 1'b1;
                        plate_mirror[c] = sweep_scratch[c];
                    end
                end
            end
            if (!moved)
            begin
                break;
            end
        end
    endtask

    // Applies one accepted command to the mirror and queues the report it causes.
    task automatic apply_to_mirror(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] row,
                                   input logic [COORD_W-1:0] col, input logic [CELL_W-1:0] val);
        int c;
        logic [CELL_W-1:0] lo;
        logic [CELL_W-1:0] hi;
        c = int'(row) * GRID + int'(col);
        case (cmd)
            CMD_WRITE:
            begin
                plate_mirror[c] = val;
            end
            CMD_RUN:
            begin
                relax_mirror(lo, hi);
                pending_reports.push_back('{kind: KIND_RUN, max_value: hi, min_value: lo,
                                            cell_value: '0});
            end
            CMD_READ:
            begin
                pending_reports.push_back('{kind: KIND_READ, max_value: '0, min_value: '0,
                                            cell_value: plate_mirror[c]});
            end
            default:
            begin
                // An unknown command leaves the plate alone and owes no report.
            end
        endcase
    endtask

    // Sends one command transaction after a random gap. Valid stays high between
    // back-to-back transactions, so it is never lowered and raised in one step.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] col, input logic [CELL_W-1:0] val);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, col, row};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        apply_to_mirror(cmd, row, col, val);
        if (cmd != CMD_IGNORED)
        begin
            commands_sent++;
        end
    endtask

    task automatic issue_run();
        send_item(CMD_RUN, COORD_W'($urandom), COORD_W'($urandom), CELL_W'($urandom));
    endtask

    task automatic read_cell(input int row, input int col);
        send_item(CMD_READ, COORD_W'(row), COORD_W'(col), CELL_W'($urandom));
    endtask

    // Mostly random 24-bit temperatures, with the extremes and tiny values mixed in
    // so that truncation of the quarter shows up.
    function automatic logic [CELL_W-1:0] draw_temperature();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CELL_ONES;
            2: return CELL_W'($urandom_range(0, 15));
            default: return CELL_W'($urandom);
        endcase
    endfunction

    task automatic load_square(input int n);
        for (int r = 0; r < n; r++)
        begin
            for (int c = 0; c < n; c++)
            begin
                send_item(CMD_WRITE, COORD_W'(r), COORD_W'(c), draw_temperature());
            end
        end
    endtask

    // Waits until every owed report has arrived, then waits out the settle time so that a
    // trailing write has landed before the registers change.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SWEEP_COUNT)
        begin
            mirror_sweeps = data;
        end
        else
        begin
            mirror_size = data[SIZE_W-1:0];
        end
    endtask

    // The upper byte of a size write is junk that the register must drop.
    task automatic configure(input logic [SWEEP_W-1:0] sweeps, input logic [SIZE_W-1:0] size);
        quiesce();
        cfg_write(CFG_SWEEP_COUNT, sweeps);
        cfg_write(CFG_ACTIVE_SIZE, {8'($urandom), size});
    endtask

    // Loads the corner square, relaxes it once at its full size, then a few sweeps
    // one size smaller, so the edge copy outside the active square is exercised.
    // A size above the grid stands for the whole grid, which holds unloaded cells,
    // so it is only run with a sweep count of zero. The last run at the smallest
    // size that has an interior keeps the next runs cheap, since a sweep also pays
    // for the square of the previous run.
    task automatic load_and_relax_test();
        configure(16'd1, SIZE_W'(LOAD_SIZE));
        load_square(LOAD_SIZE);
        issue_run();
        read_cell(0, 0);
        read_cell(LOAD_SIZE - 1, LOAD_SIZE - 1);
        read_cell(1, 1);
        read_cell(LOAD_SIZE - 2, LOAD_SIZE - 2);
        read_cell(LOAD_SIZE / 2, LOAD_SIZE / 3);
        configure(16'd3, SIZE_W'(LOAD_SIZE - 1));
        issue_run();
        read_cell(LOAD_SIZE - 3, 1);
        read_cell(1, LOAD_SIZE - 3);
        read_cell(LOAD_SIZE - 2, LOAD_SIZE - 2);
        read_cell(LOAD_SIZE - 1, 1);
        configure(16'd0, 8'hFF);
        issue_run();
        read_cell(1, 1);
        configure(16'd1, 8'd3);
        issue_run();
        read_cell(1, 1);
    endtask

    // Sizes below three have no interior, and a sweep count of zero does nothing:
    // either way the run reports all ones for the minimum and zero for the maximum.
    task automatic edge_size_test();
        for (int n = 0; n < 3; n++)
        begin
            configure(SWEEP_W'($urandom_range(1, 50)), SIZE_W'(n));
            issue_run();
            read_cell(1, 1);
        end
        configure(16'd0, 8'd6);
        issue_run();
        read_cell(2, 3);
        read_cell(4, 4);
    endtask

    // Unknown commands must neither write a cell nor send a report.
    task automatic unknown_command_test();
        int r;
        int c;
        send_item(CMD_IGNORED, COORD_W'(LOAD_SIZE - 1), COORD_W'(LOAD_SIZE - 1), CELL_ONES);
        read_cell(LOAD_SIZE - 1, LOAD_SIZE - 1);
        repeat (3)
        begin
            r = $urandom_range(0, LOAD_SIZE - 1);
            c = $urandom_range(0, LOAD_SIZE - 1);
            send_item(CMD_IGNORED, COORD_W'(r), COORD_W'(c), CELL_W'($urandom));
            read_cell(r, c);
        end
    endtask

    // Four all-ones neighbors need the full 26-bit sum; three ones and a zero must
    // truncate to zero.
    task automatic extreme_value_test();
        configure(16'd1, 8'd3);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                send_item(CMD_WRITE, COORD_W'(r), COORD_W'(c),
                          (r == 1 && c == 1) ? CELL_W'(0) : CELL_ONES);
            end
        end
        issue_run();
        read_cell(1, 1);
        send_item(CMD_WRITE, 7'd0, 7'd1, CELL_W'(1));
        send_item(CMD_WRITE, 7'd1, 7'd0, CELL_W'(1));
        send_item(CMD_WRITE, 7'd1, 7'd2, CELL_W'(1));
        send_item(CMD_WRITE, 7'd2, 7'd1, CELL_W'(0));
        issue_run();
        read_cell(1, 1);
    endtask

    // The largest sweep count, on a 3x3 square that settles after its first sweep.
    task automatic long_run_test();
        configure(16'd1, 8'd3);
        issue_run();
        configure(16'hFFFF, 8'd3);
        send_item(CMD_WRITE, 7'd0, 7'd1, draw_temperature());
        send_item(CMD_WRITE, 7'd1, 7'd0, draw_temperature());
        send_item(CMD_WRITE, 7'd1, 7'd2, draw_temperature());
        send_item(CMD_WRITE, 7'd2, 7'd1, draw_temperature());
        issue_run();
        read_cell(1, 1);
    endtask

    function automatic int draw_gap_max();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 9;
        endcase
    endfunction

    // Random phases: pick a size and sweep count, then mix writes and reads inside
    // the active square, reads in the loaded square, stray writes anywhere, dropped commands and runs.
    task automatic random_test();
        int budget;
        int n;
        int span;
        int sweeps;
        int steps;
        int pick;
        budget = commands_sent + RANDOM_ITEMS;
        while (commands_sent < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                n = $urandom_range(0, 2);
            end
            else if (pick == 1)
            begin
                n = $urandom_range(9, LOAD_SIZE);
            end
            else
            begin
                n = $urandom_range(3, 8);
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                sweeps = 0;
            end
            else if (pick == 1 && n <= 5)
            begin
                sweeps = $urandom_range(50, 100);
            end
            else
            begin
                sweeps = $urandom_range(1, 20);
            end
            configure(SWEEP_W'(sweeps), SIZE_W'(n));
            send_gap_max = draw_gap_max();
            take_gap_max = draw_gap_max();
            span = (n < 3) ? 3 : n;
            steps = $urandom_range(5, 30);
            repeat (steps)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                begin
                    send_item(CMD_WRITE, COORD_W'($urandom_range(0, span - 1)),
                              COORD_W'($urandom_range(0, span - 1)), draw_temperature());
                end
                else if (pick < 16)
                begin
                    read_cell($urandom_range(0, span - 1), $urandom_range(0, span - 1));
                end
                else if (pick < 17)
                begin
                    send_item(CMD_WRITE, COORD_W'($urandom), COORD_W'($urandom),
                              draw_temperature());
                end
                else if (pick < 18)
                begin
                    read_cell($urandom_range(0, LOAD_SIZE - 1),
                              $urandom_range(0, LOAD_SIZE - 1));
                end
                else if (pick < 19)
                begin
                    send_item(CMD_IGNORED, COORD_W'($urandom), COORD_W'($urandom),
                              CELL_W'($urandom));
                end
                else
                begin
                    issue_run();
                end
            end
            issue_run();
            read_cell($urandom_range(0, span - 1), $urandom_range(0, span - 1));
        end
    endtask

    function automatic void check_field(input string field, input logic [CELL_W-1:0] want_v,
                                        input logic [CELL_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
            begin
                $display("mismatch in %s: expected %h, got %h", field, want_v, got_v);
            end
        end
    endfunction

    // Receiving side: stalls a random number of cycles before each report, then
    // checks the report transaction against the oldest owed report.
    initial
    begin : report_checker
        result_t want;
        result_t got;
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, take_gap_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
            begin
                @(posedge clk);
            end
            got = {m_tuser, m_tdata};
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                begin
                    $display("report transaction with none owed: %h", got);
                end
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("result_kind", CELL_W'(want.kind), CELL_W'(got.kind));
                check_field("cell_value", want.cell_value, got.cell_value);
                check_field("min_value", want.min_value, got.min_value);
                check_field("max_value", want.max_value, got.max_value);
            end
        end
    end

    // Ends the run if no transaction moves on either stream for too long.
    initial
    begin : stall_watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_WRITE;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SWEEP_COUNT;
        cfg_data      = '0;
        mismatches    = 0;
        commands_sent = 0;
        send_gap_max  = 9;
        take_gap_max  = 9;
        mirror_sweeps = RESET_SWEEP_COUNT;
        mirror_size   = RESET_ACTIVE_SIZE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_and_relax_test();
        edge_size_test();
        unknown_command_test();
        extreme_value_test();
        long_run_test();
        random_test();

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
